FILE: src/cvf_pkg.sv
// Package for the 3x3 fold filter: sizes, pixel and weight types, control structs.
// Used by the column cell and the top level; depends on nothing.
`timescale 1ns / 1ps

package cvf_pkg;

    localparam int LINE_MAX = 256;
    localparam int LINE_AW  = $clog2(LINE_MAX);

    localparam int PIX_W    = 8;
    localparam int PROD_W   = 17;
    localparam int COLSUM_W = 19;
    localparam int SUM_W    = 21;

    localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;
    localparam logic [7:0]       SIZE_MIN = 8'd3;

    // Register indexes of the configuration port.
    localparam logic [7:0] CFG_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_HEIGHT = 8'd1;
    localparam logic [7:0] CFG_RING   = 8'd2;
    localparam logic [7:0] CFG_CENTER = 8'd3;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COLSUM_W-1:0] colsum_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } column_t;

    typedef struct packed {
        logic signed [7:0] top;
        logic signed [7:0] mid;
        logic signed [7:0] bot;
    } weights_t;

    // Load enables for one cell: window shift, product stage, column sum stage.
    typedef struct packed {
        logic shift;
        logic prod;
        logic sum;
    } cell_ctrl_t;

    typedef struct packed {
        logic       border;
        logic [7:0] col;
        logic [7:0] row;
        logic       last;
    } meta_t;

endpackage

FILE: src/cvf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/cvf_cell.sv
// One window column cell: holds a column of three pixels, passes it to the
// next cell on each shift, and forms the weighted column sum in two stages. Uses cvf_pkg.
`timescale 1ns / 1ps

module cvf_cell
    import cvf_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  column_t    col_in,
    input  weights_t   weights,
    output column_t    col_out,
    output colsum_t    col_sum
);

    column_t col_reg;
    prod_t   p_top_reg, p_mid_reg, p_bot_reg;
    prod_t   p_top_next, p_mid_next, p_bot_next;
    colsum_t sum_reg, sum_next;

    // Pixels are unsigned, so they get a zero sign bit before the signed multiply.
    always_comb
    begin
        p_top_next = $signed({1'b0, col_reg.top}) * weights.top;
        p_mid_next = $signed({1'b0, col_reg.mid}) * weights.mid;
        p_bot_next = $signed({1'b0, col_reg.bot}) * weights.bot;
        sum_next   = COLSUM_W'(p_top_reg) + COLSUM_W'(p_mid_reg) + COLSUM_W'(p_bot_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
        if (ctrl.prod)
        begin
            p_top_reg <= p_top_next;
            p_mid_reg <= p_mid_next;
            p_bot_reg <= p_bot_next;
        end
        if (ctrl.sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign col_out = col_reg;
    assign col_sum = sum_reg;

endmodule

FILE: src/conv3x3_abs_fold_filter_core.sv
// Top level of the streaming 3x3 fold filter: counters, line stores, a chain
// of three column cells, the final sum and fold. Uses cvf_pkg, cvf_ram, cvf_cell.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    pixel_value
// output    out        out_valid/out_ready  out_value, out_col, out_row, frame_last
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel request is taken per cycle unless back-pressure from out_ready fills every stage.
// Both line store RAMs are read one column ahead; the window moves one column per accepted pixel.
// Reset zeroes counters, weights, stage valids, sets sizes to 255; line stores need no clearing.
// Stages advance independently, so in_ready drops only when every stage is full.
// Pixels in column 0 or row 0 of the input make no result.

module conv3x3_abs_fold_filter_core
    import cvf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_value,
    output logic [7:0]  out_col,
    output logic [7:0]  out_row,
    output logic        frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [7:0]          width_reg, height_reg, center_reg;
    logic [63:0]         ring_reg;
    logic [7:0]          col_reg, col_next, row_reg, row_next;
    logic [7:0]          w_eff, h_eff;
    logic [8:0]          x_plus, y_plus;
    logic                row_end, frame_end, emit;
    logic                in_accept, cfg_accept;
    logic [LINE_AW-1:0]  wr_addr, rd_addr;
    pix_t                mid_pix, top_pix;

    logic                v0_reg, v1_reg, v2_reg, v3_reg, ov_reg;
    logic                v0_next;
    logic                e0, e1, e2, e3, e_out;
    meta_t               m0_reg, m1_reg, m2_reg, m3_reg, m0_next;
    sum_t                total_reg, total_next;
    sum_t                mag;
    pix_t                val_next, val_reg;
    meta_t               om_reg;

    cell_ctrl_t          ctrl;
    column_t             c0_in, c0_out, c1_out, c2_out;
    weights_t            w_right, w_center, w_left;
    colsum_t             s_right, s_center, s_left;

    // Stage enables: a stage loads when it is empty or its successor loads.
    assign e_out = !ov_reg || out_ready;
    assign e3    = !v3_reg || e_out;
    assign e2    = !v2_reg || e3;
    assign e1    = !v1_reg || e2;
    assign e0    = !v0_reg || e1;

    assign in_ready   = e0;
    assign in_accept  = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= PIX_MAX;
            height_reg <= PIX_MAX;
            ring_reg   <= '0;
            center_reg <= '0;
        end
        else if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[7:0];
                CFG_HEIGHT: height_reg <= cfg_data[7:0];
                CFG_RING:   ring_reg   <= cfg_data;
                CFG_CENTER: center_reg <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // Raster counters.
    always_comb
    begin
        w_eff     = (width_reg < SIZE_MIN) ? SIZE_MIN : width_reg;
        h_eff     = (height_reg < SIZE_MIN) ? SIZE_MIN : height_reg;
        x_plus    = {1'b0, col_reg} + 9'd1;
        y_plus    = {1'b0, row_reg} + 9'd1;
        row_end   = x_plus >= {1'b0, w_eff};
        frame_end = y_plus >= {1'b0, h_eff};
        col_next  = row_end ? 8'd0 : x_plus[7:0];
        row_next  = row_reg;
        if (row_end)
        begin
            row_next = frame_end ? 8'd0 : y_plus[7:0];
        end
        emit = (col_reg != 8'd0) && (row_reg != 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // The read port runs one column ahead so the data is ready when the pixel arrives.
    assign wr_addr = LINE_AW'(col_reg);
    assign rd_addr = in_accept ? LINE_AW'(col_next) : LINE_AW'(col_reg);

    cvf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_MAX)
    ) u_line_prev (
        .clk   (clk),
        .we    (in_accept),
        .waddr (wr_addr),
        .wdata (pixel_value),
        .raddr (rd_addr),
        .rdata (mid_pix)
    );

    cvf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_MAX)
    ) u_line_older (
        .clk   (clk),
        .we    (in_accept),
        .waddr (wr_addr),
        .wdata (mid_pix),
        .raddr (rd_addr),
        .rdata (top_pix)
    );

    // Column cell chain: right column enters from the line stores and input.
    assign ctrl.shift = in_accept;
    assign ctrl.prod  = e1;
    assign ctrl.sum   = e2;

    assign c0_in.top = top_pix;
    assign c0_in.mid = mid_pix;
    assign c0_in.bot = pixel_value;

    assign w_right.top  = ring_reg[55:48];
    assign w_right.mid  = ring_reg[47:40];
    assign w_right.bot  = ring_reg[39:32];
    assign w_center.top = ring_reg[63:56];
    assign w_center.mid = center_reg;
    assign w_center.bot = ring_reg[31:24];
    assign w_left.top   = ring_reg[7:0];
    assign w_left.mid   = ring_reg[15:8];
    assign w_left.bot   = ring_reg[23:16];

    cvf_cell u_cell_right (
        .clk     (clk),
        .ctrl    (ctrl),
        .col_in  (c0_in),
        .weights (w_right),
        .col_out (c0_out),
        .col_sum (s_right)
    );

    cvf_cell u_cell_center (
        .clk     (clk),
        .ctrl    (ctrl),
        .col_in  (c0_out),
        .weights (w_center),
        .col_out (c1_out),
        .col_sum (s_center)
    );

    cvf_cell u_cell_left (
        .clk     (clk),
        .ctrl    (ctrl),
        .col_in  (c1_out),
        .weights (w_left),
        .col_out (c2_out),
        .col_sum (s_left)
    );

    // Result position and flags travel alongside the cell stages.
    always_comb
    begin
        v0_next       = in_accept && emit;
        m0_next.col   = col_reg - 8'd1;
        m0_next.row   = row_reg - 8'd1;
        m0_next.border = (col_reg == 8'd1) || (row_reg == 8'd1);
        m0_next.last  = row_end && frame_end;
        total_next    = SUM_W'(s_right) + SUM_W'(s_center) + SUM_W'(s_left);
        mag           = total_reg[SUM_W-1] ? -total_reg : total_reg;
        if (m3_reg.border)
        begin
            val_next = PIX_ZERO;
        end
        else if (mag > SUM_W'(PIX_MAX))
        begin
            val_next = PIX_MAX;
        end
        else
        begin
            val_next = mag[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (e0)
            begin
                v0_reg <= v0_next;
            end
            if (e1)
            begin
                v1_reg <= v0_reg;
            end
            if (e2)
            begin
                v2_reg <= v1_reg;
            end
            if (e3)
            begin
                v3_reg <= v2_reg;
            end
            if (e_out)
            begin
                ov_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            m0_reg <= m0_next;
        end
        if (e1)
        begin
            m1_reg <= m0_reg;
        end
        if (e2)
        begin
            m2_reg <= m1_reg;
        end
        if (e3)
        begin
            m3_reg    <= m2_reg;
            total_reg <= total_next;
        end
        if (e_out)
        begin
            om_reg  <= m3_reg;
            val_reg <= val_next;
        end
    end

    assign out_valid  = ov_reg;
    assign out_value  = val_reg;
    assign out_col    = om_reg.col;
    assign out_row    = om_reg.row;
    assign frame_last = om_reg.last;

`ifndef SYNTHESIS
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_col == 8'd0 || out_row == 8'd0) |-> out_value == 8'd0)
        else $error("border result is not zero");

    a_first_col_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && col_reg == 8'd0 |=> !v0_reg)
        else $error("column 0 request entered the result pipeline");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && row_end && frame_end |=> col_reg == 8'd0 && row_reg == 8'd0)
        else $error("counters did not wrap at the end of the frame");
`endif

endmodule

FILE: bench/conv3x3_abs_fold_filter_core_tb.sv
// Self-checking bench for conv3x3_abs_fold_filter_core: a directed table, then random frames.
// Holds its own filter predictor; depends on cvf_pkg and the core RTL only.
`timescale 1ns / 1ps

module conv3x3_abs_fold_filter_core_tb
    import cvf_pkg::*;
();

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] col;
        logic [7:0] row;
        logic       last;
    } pix_result_t;

    typedef enum logic {STEP_PIXEL, STEP_CFG} step_kind_t;

    typedef struct {
        step_kind_t  kind;
        logic [7:0]  index;
        logic [63:0] data;
        bit          typed;
        pix_result_t res;
    } step_t;

    localparam int RANDOM_ITEMS = 1750;
    localparam int QUIET_FROM   = 1600;
    localparam int DRAIN_PAUSE  = 8;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [7:0]  pixel_value = 8'd0;
    logic        out_ready   = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [7:0]  cfg_index   = 8'd0;
    logic [63:0] cfg_data    = 64'd0;
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  out_value;
    logic [7:0]  out_col;
    logic [7:0]  out_row;
    logic        frame_last;
    logic        cfg_ready;

    conv3x3_abs_fold_filter_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_value   (out_value),
        .out_col     (out_col),
        .out_row     (out_row),
        .frame_last  (frame_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Predictor state: line stores, window, counters and register copies.
    pix_t        line_prev [256];
    pix_t        line_older[256];
    bit [255:0]  prev_def;
    bit [255:0]  older_def;
    pix_t        win[6];
    logic [7:0]  pos_col;
    logic [7:0]  pos_row;
    logic [7:0]  reg_width;
    logic [7:0]  reg_height;
    logic [63:0] reg_ring;
    logic [7:0]  reg_center;

    pix_result_t filtered_q[$];
    step_t       stim_table[$];
    int          mismatches  = 0;
    int          items_sent  = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_stall    = 0;
    int          pix_style   = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("conv3x3_abs_fold_filter_core_tb NOT OK");
        $finish;
    end

    function automatic int unsigned eff_size(logic [7:0] v);
        return (v < SIZE_MIN) ? 3 : int'(v);
    endfunction

    function automatic int weight_of(logic [7:0] b);
        return int'($signed(b));
    endfunction

    function automatic logic [63:0] with_low_byte(logic [7:0] b);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v[7:0] = b;
        return v;
    endfunction

    // A wider row reads line store columns that may never have been written,
    // unless the frame is just starting or every such column holds data.
    function automatic bit width_ok(logic [7:0] nw);
        int unsigned lim;
        lim = eff_size(nw);
        if ((pos_col == 0 && pos_row == 0) || lim <= eff_size(reg_width))
            return 1'b1;
        for (int c = 0; c < lim; c++)
            if (!(prev_def[c] && older_def[c]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic pix_t draw_pixel(int style);
        case (style)
            0: return pix_t'($urandom_range(0, 255));
            1: return pix_t'($urandom_range(0, 15));
            2: return $urandom_range(0, 1) ? PIX_MAX : PIX_ZERO;
            default: return pix_t'($urandom_range(200, 255));
        endcase
    endfunction

    task automatic filter_step(input pix_t p, output bit has, output pix_result_t r);
        int unsigned w, h, x, y;
        pix_t mid, top;
        bit row_end, frame_end;
        int acc;
        w = eff_size(reg_width);
        h = eff_size(reg_height);
        x = pos_col;
        y = pos_row;
        mid = line_prev[pos_col];
        top = line_older[pos_col];
        row_end = (x + 1 >= w);
        frame_end = (y + 1 >= h);
        has = (x >= 1 && y >= 1);
        r = '0;
        if (has)
        begin
            r.col = 8'(x - 1);
            r.row = 8'(y - 1);
            r.last = row_end && frame_end;
            if (x != 1 && y != 1)
            begin
                acc = int'(win[0]) * weight_of(reg_ring[7:0])
                    + int'(win[1]) * weight_of(reg_ring[15:8])
                    + int'(win[2]) * weight_of(reg_ring[23:16])
                    + int'(win[5]) * weight_of(reg_ring[31:24])
                    + int'(p)      * weight_of(reg_ring[39:32])
                    + int'(mid)    * weight_of(reg_ring[47:40])
                    + int'(top)    * weight_of(reg_ring[55:48])
                    + int'(win[3]) * weight_of(reg_ring[63:56])
                    + int'(win[4]) * weight_of(reg_center);
                if (acc < 0)
                    acc = -acc;
                r.value = (acc > 255) ? PIX_MAX : acc[7:0];
            end
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = p;
        older_def[pos_col] = prev_def[pos_col];
        prev_def[pos_col] = 1'b1;
        line_older[pos_col] = mid;
        line_prev[pos_col] = p;
        if (row_end)
        begin
            pos_col = 8'd0;
            pos_row = frame_end ? 8'd0 : 8'(y + 1);
        end
        else
        begin
            pos_col = 8'(x + 1);
        end
    endtask

    task automatic send_pixel(input pix_t v, input bit typed, input pix_result_t typed_res);
        bit has;
        pix_result_t r;
        int gap;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            pixel_value <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_value <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        filter_step(v, has, r);
        if (typed)
            filtered_q.push_back(typed_res);
        else if (has)
            filtered_q.push_back(r);
        items_sent++;
    endtask

    // Registers change only once the core has drained and settled.
    task automatic write_reg(input logic [7:0] idx, input logic [63:0] data);
        in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  reg_width = data[7:0];
            CFG_HEIGHT: reg_height = data[7:0];
            CFG_RING:   reg_ring = data;
            CFG_CENTER: reg_center = data[7:0];
            default: ;
        endcase
    endtask

    task automatic pick_weights();
        logic [63:0] ring;
        logic [7:0] ctr;
        logic [7:0] one;
        int k;
        case ($urandom_range(0, 3))
            0:
            begin
                ring = {$urandom, $urandom};
                ctr = 8'($urandom);
            end
            1:
            begin
                for (k = 0; k < 8; k++)
                    ring[8*k +: 8] = 8'($urandom_range(0, 4) - 2);
                ctr = 8'($urandom_range(0, 4) - 2);
            end
            2:
            begin
                ring = '0;
                ctr = '0;
                one = $urandom_range(0, 1) ? 8'h01 : 8'hFF;
                k = $urandom_range(0, 8);
                if (k == 8)
                    ctr = one;
                else
                    ring[8*k +: 8] = one;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        ring = '0;
                        ctr = 8'h00;
                    end
                    1:
                    begin
                        ring = {8{8'h80}};
                        ctr = 8'h80;
                    end
                    2:
                    begin
                        ring = {8{8'h7F}};
                        ctr = 8'h7F;
                    end
                    default:
                    begin
                        ring = {8{8'hFF}};
                        ctr = 8'hFF;
                    end
                endcase
            end
        endcase
        write_reg(CFG_RING, ring);
        write_reg(CFG_CENTER, with_low_byte(ctr));
    endtask

    task automatic mid_frame_change();
        logic [7:0] nw;
        case ($urandom_range(0, 3))
            0:
            begin
                nw = 8'($urandom_range(0, 14));
                if (!width_ok(nw))
                    nw = reg_width;
                write_reg(CFG_WIDTH, with_low_byte(nw));
            end
            1: write_reg(CFG_HEIGHT, with_low_byte(8'($urandom_range(0, 10))));
            2: pick_weights();
            default: write_reg(8'($urandom_range(4, 255)), {$urandom, $urandom});
        endcase
    endtask

    // Sends pixels until the frame wraps around; change_at and pause_at are item
    // offsets inside the frame, or -1.
    task automatic send_frame(input int change_at, input int pause_at);
        int k;
        k = 0;
        do
        begin
            if (k == change_at)
                mid_frame_change();
            if (k == pause_at)
            begin
                while (filtered_q.size() != 0)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                end
            end
            send_pixel(draw_pixel(pix_style), 1'b0, '0);
            k++;
        end
        while (pos_col != 0 || pos_row != 0);
    endtask

    task automatic add_cfg(input logic [7:0] idx, input logic [63:0] data);
        step_t s;
        s.kind = STEP_CFG;
        s.index = idx;
        s.data = data;
        s.typed = 1'b0;
        s.res = '0;
        stim_table.push_back(s);
    endtask

    task automatic add_px(input pix_t v);
        step_t s;
        s.kind = STEP_PIXEL;
        s.index = '0;
        s.data = {56'd0, v};
        s.typed = 1'b0;
        s.res = '0;
        stim_table.push_back(s);
    endtask

    task automatic add_px_exp(input pix_t v, input logic [7:0] val, input logic [7:0] c,
                              input logic [7:0] r, input logic l);
        step_t s;
        s.kind = STEP_PIXEL;
        s.index = '0;
        s.data = {56'd0, v};
        s.typed = 1'b1;
        s.res = '{value: val, col: c, row: r, last: l};
        stim_table.push_back(s);
    endtask

    always @(posedge clk)
    begin : result_side
        pix_result_t got;
        pix_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {out_value, out_col, out_row, frame_last};
                if (filtered_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: value %0d col %0d row %0d last %0b",
                                 got.value, got.col, got.row, got.last);
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"mismatch: expected value %0d col %0d row %0d last %0b,",
                                      " got value %0d col %0d row %0d last %0b"},
                                     want.value, want.col, want.row, want.last,
                                     got.value, got.col, got.row, got.last);
                    end
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                out_ready <= 1'b0;
            end
            else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                rx_stall = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int random_start;
        int phase;
        int frames;
        step_t s;
        foreach (line_prev[i])
        begin
            line_prev[i] = '0;
            line_older[i] = '0;
        end
        prev_def = '0;
        older_def = '0;
        foreach (win[i])
            win[i] = '0;
        pos_col = '0;
        pos_row = '0;
        reg_width = 8'd255;
        reg_height = 8'd255;
        reg_ring = '0;
        reg_center = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unit center weight: the only inner pixel passes unchanged.
        add_cfg(CFG_WIDTH, 64'd3);
        add_cfg(CFG_HEIGHT, 64'd3);
        add_cfg(CFG_RING, 64'd0);
        add_cfg(CFG_CENTER, 64'd1);
        add_px(8'd0);
        add_px(8'd255);
        add_px(8'd0);
        add_px(8'd255);
        add_px_exp(8'd200, 8'd0, 8'd0, 8'd0, 1'b0);
        add_px_exp(8'd255, 8'd0, 8'd1, 8'd0, 1'b0);
        add_px(8'd0);
        add_px_exp(8'd255, 8'd0, 8'd0, 8'd1, 1'b0);
        add_px_exp(8'd0, 8'd200, 8'd1, 8'd1, 1'b1);
        // Most negative weights on white: a huge negative sum folds and saturates.
        add_cfg(CFG_RING, {8{8'h80}});
        add_cfg(CFG_CENTER, 64'h80);
        for (int i = 0; i < 4; i++)
            add_px(8'd255);
        add_px_exp(8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
        add_px_exp(8'd255, 8'd0, 8'd1, 8'd0, 1'b0);
        add_px(8'd255);
        add_px_exp(8'd255, 8'd0, 8'd0, 8'd1, 1'b0);
        add_px_exp(8'd255, 8'd255, 8'd1, 8'd1, 1'b1);
        // Sizes below the minimum act as three; mixed weights go to the predictor.
        add_cfg(CFG_WIDTH, 64'd1);
        add_cfg(CFG_HEIGHT, 64'd2);
        add_cfg(CFG_RING, 64'h7F01_FF80_02FE_7F00);
        add_cfg(CFG_CENTER, 64'hFF);
        add_px(8'd17);
        add_px(8'd200);
        add_px(8'd3);
        add_px(8'd255);
        add_px(8'd0);
        add_px(8'd128);
        add_px(8'd64);
        add_px(8'd1);
        add_px(8'd254);

        foreach (stim_table[i])
        begin
            s = stim_table[i];
            if (s.kind == STEP_CFG)
                write_reg(s.index, s.data);
            else
                send_pixel(s.data[7:0], s.typed, s.res);
        end

        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (items_sent - random_start >= QUIET_FROM)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
                rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
            end
            pix_style = $urandom_range(0, 3);
            if (phase == 2)
            begin
                // One full frame at the widest row.
                pix_style = 0;
                write_reg(CFG_WIDTH, with_low_byte(8'd255));
                write_reg(CFG_HEIGHT, with_low_byte(8'd3));
                pick_weights();
                send_frame(-1, -1);
            end
            else if (phase == 5)
            begin
                // Tallest frame, cut short by shrinking the height mid-frame.
                write_reg(CFG_WIDTH, with_low_byte(8'd4));
                write_reg(CFG_HEIGHT, with_low_byte(8'd255));
                pick_weights();
                for (int i = 0; i < 26; i++)
                    send_pixel(draw_pixel(pix_style), 1'b0, '0);
                write_reg(CFG_HEIGHT, with_low_byte(8'd3));
                send_frame(-1, -1);
            end
            else
            begin
                write_reg(CFG_WIDTH, with_low_byte(($urandom_range(0, 9) == 0) ?
                          8'($urandom_range(0, 2)) : 8'($urandom_range(3, 12))));
                write_reg(CFG_HEIGHT, with_low_byte(($urandom_range(0, 9) == 0) ?
                          8'($urandom_range(0, 2)) : 8'($urandom_range(3, 8))));
                pick_weights();
                if ($urandom_range(0, 5) == 0)
                    write_reg(8'($urandom_range(4, 255)), {$urandom, $urandom});
                frames = $urandom_range(1, 3);
                repeat (frames)
                    send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : -1,
                               (phase == 3) ? 5 : -1);
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && filtered_q.size() == 0)
            $display("conv3x3_abs_fold_filter_core_tb OK");
        else
            $display("conv3x3_abs_fold_filter_core_tb NOT OK");
        $finish;
    end

endmodule
